// File: rtl/core/nnpr_pkg.sv
package nnpr_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int CNT_W = 6;
    localparam logic [CNT_W-1:0] LINK_STEPS = 6'd33;
    localparam logic [CNT_W-1:0] FIN_STEPS = 6'd32;

    typedef struct packed {
        logic capture;
        logic mul_p;
        logic div_link;
        logic div_step;
        logic mul_w;
        logic term_w;
        logic acc_w;
        logic mul_d;
        logic term_d;
        logic acc_d;
        logic fin_abs;
        logic fin_zero;
        logic fin_sat;
        logic div_fin;
        logic fin_div;
        logic out_load;
    } nnpr_cmd_t;

    typedef struct packed {
        logic last;
        logic s_zero;
        logic csum_zero;
        logic fin_ovf;
    } nnpr_stat_t;

endpackage

// File: rtl/core/nnpr_ctrl.sv
module nnpr_ctrl
    import nnpr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  nnpr_stat_t stat,
    output nnpr_cmd_t  cmd
);

    typedef enum logic [3:0] {
        IDLE, MUL_P, DIV_LINK, DIV_RUN_L, MUL_W, TERM_W, ACC_W, MUL_D, TERM_D,
        ACC_D, FIN_ABS, FIN_CHK, DIV_RUN_F, FIN_DIV, OUTPUT
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_tvalid_reg, m_tvalid_next;

    assign s_tready = (state_reg == IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        cmd           = '0;
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (state_reg)
            IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = MUL_P;
                end
            end
            MUL_P: begin
                cmd.mul_p  = 1'b1;
                state_next = DIV_LINK;
            end
            DIV_LINK: begin
                cmd.div_link = 1'b1;
                cnt_next     = LINK_STEPS;
                state_next   = stat.s_zero ? MUL_W : DIV_RUN_L;
            end
            DIV_RUN_L: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == 1) state_next = MUL_W;
            end
            MUL_W: begin
                cmd.mul_w  = 1'b1;
                state_next = TERM_W;
            end
            TERM_W: begin
                cmd.term_w = 1'b1;
                state_next = ACC_W;
            end
            ACC_W: begin
                cmd.acc_w  = 1'b1;
                state_next = MUL_D;
            end
            MUL_D: begin
                cmd.mul_d  = 1'b1;
                state_next = TERM_D;
            end
            TERM_D: begin
                cmd.term_d = 1'b1;
                state_next = ACC_D;
            end
            ACC_D: begin
                cmd.acc_d  = 1'b1;
                state_next = stat.last ? FIN_ABS : IDLE;
            end
            FIN_ABS: begin
                cmd.fin_abs = 1'b1;
                state_next  = FIN_CHK;
            end
            FIN_CHK: begin
                if (stat.csum_zero) begin
                    cmd.fin_zero = 1'b1;
                    state_next   = OUTPUT;
                end else if (stat.fin_ovf) begin
                    cmd.fin_sat = 1'b1;
                    state_next  = OUTPUT;
                end else begin
                    cmd.div_fin = 1'b1;
                    cnt_next    = FIN_STEPS;
                    state_next  = DIV_RUN_F;
                end
            end
            DIV_RUN_F: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == 1) state_next = FIN_DIV;
            end
            FIN_DIV: begin
                cmd.fin_div = 1'b1;
                state_next  = OUTPUT;
            end
            OUTPUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = IDLE;
                end
            end
            default: state_next = IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

// File: rtl/core/nnpr_datapath.sv
module nnpr_datapath
    import nnpr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic [127:0] s_tdata,
    input  logic         s_tlast,
    input  nnpr_cmd_t    cmd,
    output nnpr_stat_t   stat,
    output logic [79:0]  m_tdata,
    output logic [1:0]   m_tuser
);

    localparam int DW = 64 + FRAC_BITS;

    logic [31:0] c1_reg, xo_reg, c2_reg, xn_reg;
    logic        last_reg;
    logic [32:0] s_reg;
    logic [64:0] prod_reg;
    logic [47:0] rem_reg, div_reg;
    logic [32:0] low_reg;
    logic [63:0] mag_reg;
    logic        mneg_reg;
    logic [47:0] csum_reg;
    logic [63:0] wsum_reg, fsum_reg;
    logic        satseen_reg;
    logic [63:0] w_reg;
    logic        wneg_reg;
    logic [31:0] np_reg;
    logic        zero_reg, rsat_reg;
    logic [31:0] np_out_reg;
    logic [47:0] flux_out_reg;
    logic        zero_out_reg, sat_out_reg;

    logic [32:0] xn_ext, m_w, diff, m_d;
    logic [31:0] mul_a;
    logic [32:0] mul_b;
    logic [32:0] term_m;
    logic        term_neg;
    logic [65:0] pfull;
    logic [48:0] trial;
    logic        ge;
    logic [48:0] csum_add;
    logic [63:0] acc_a;
    logic [64:0] acc_sum;
    logic [63:0] acc_res;
    logic        acc_ovf;
    logic [DW-1:0] dfin;
    logic [DW-33:0] dhi;
    logic [31:0] q;
    logic        q_big;
    logic        flux_clamp;
    logic [47:0] flux_sat;

    assign xn_ext = {xn_reg[31], xn_reg};
    assign m_w    = xn_reg[31] ? 33'(-xn_ext) : xn_ext;
    assign diff   = {xo_reg[31], xo_reg} - xn_ext;
    assign m_d    = diff[32] ? 33'(-diff) : diff;

    always_comb begin
        mul_a = low_reg[31:0];
        mul_b = cmd.mul_d ? m_d : m_w;
        if (cmd.mul_p) begin
            mul_a = c1_reg;
            mul_b = {1'b0, c2_reg};
        end
    end

    assign term_m   = cmd.term_d ? m_d : m_w;
    assign term_neg = cmd.term_d ? diff[32] : xn_reg[31];
    assign pfull = {1'b0, prod_reg}
                 + (low_reg[32] ? {term_m, 33'b0} >> 1 : 66'd0)
                 + (term_neg ? 66'((66'd1 << FRAC_BITS) - 66'd1) : 66'd0);

    assign trial = {rem_reg, low_reg[32]};
    assign ge    = trial >= {1'b0, div_reg};

    assign csum_add = {1'b0, csum_reg} + 49'(low_reg);
    assign acc_a    = cmd.acc_d ? fsum_reg : wsum_reg;
    assign acc_sum  = mneg_reg ? {acc_a[63], acc_a} - {1'b0, mag_reg}
                               : {acc_a[63], acc_a} + {1'b0, mag_reg};
    assign acc_ovf  = acc_sum[64] != acc_sum[63];
    assign acc_res  = acc_ovf ? (acc_sum[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}})
                              : acc_sum[63:0];

    assign dfin = {w_reg, {FRAC_BITS{1'b0}}};
    assign dhi  = dfin[DW-1:32];
    assign q    = low_reg[31:0];
    assign q_big = wneg_reg ? (q > 32'h8000_0000) : (q > 32'h7fff_ffff);

    assign flux_clamp = !((&fsum_reg[63:47]) || !(|fsum_reg[63:47]));
    assign flux_sat   = flux_clamp ? (fsum_reg[63] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}})
                                   : fsum_reg[47:0];

    assign stat.last      = last_reg;
    assign stat.s_zero    = (s_reg == 33'd0);
    assign stat.csum_zero = (csum_reg == 48'd0);
    assign stat.fin_ovf   = 64'(dhi) >= 64'(csum_reg);

    assign m_tdata = {flux_out_reg, np_out_reg};
    assign m_tuser = {sat_out_reg, zero_out_reg};

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            c1_reg   <= s_tdata[31:0];
            xo_reg   <= s_tdata[63:32];
            c2_reg   <= s_tdata[95:64];
            xn_reg   <= s_tdata[127:96];
            last_reg <= s_tlast;
        end
        if (cmd.mul_p) s_reg <= {1'b0, c1_reg} + {1'b0, c2_reg};
        if (cmd.mul_p || cmd.mul_w || cmd.mul_d) begin
            prod_reg <= {33'd0, mul_a} * {32'd0, mul_b};
        end
        if (cmd.div_link) begin
            div_reg <= 48'(s_reg);
            rem_reg <= stat.s_zero ? 48'd0 : 48'(prod_reg[63:32]);
            low_reg <= stat.s_zero ? 33'd0 : {prod_reg[31:0], 1'b0};
        end
        if (cmd.div_fin) begin
            div_reg <= csum_reg;
            rem_reg <= 48'(dhi);
            low_reg <= {dfin[31:0], 1'b0};
        end
        if (cmd.div_step) begin
            rem_reg <= ge ? 48'(trial - {1'b0, div_reg}) : trial[47:0];
            low_reg <= {low_reg[31:0], ge};
        end
        if (cmd.term_w || cmd.term_d) begin
            mag_reg  <= 64'(pfull >> FRAC_BITS);
            mneg_reg <= term_neg;
        end
        if (cmd.fin_abs) begin
            w_reg    <= wsum_reg[63] ? 64'(-wsum_reg) : wsum_reg;
            wneg_reg <= wsum_reg[63];
        end
        if (cmd.fin_zero) begin
            np_reg   <= xo_reg;
            zero_reg <= 1'b1;
            rsat_reg <= 1'b0;
        end
        if (cmd.fin_sat) begin
            np_reg   <= wneg_reg ? 32'h8000_0000 : 32'h7fff_ffff;
            zero_reg <= 1'b0;
            rsat_reg <= 1'b1;
        end
        if (cmd.fin_div) begin
            zero_reg <= 1'b0;
            rsat_reg <= q_big;
            if (q_big) np_reg <= wneg_reg ? 32'h8000_0000 : 32'h7fff_ffff;
            else       np_reg <= wneg_reg ? 32'(-q) : q;
        end
        if (cmd.out_load) begin
            np_out_reg   <= np_reg;
            flux_out_reg <= flux_sat;
            zero_out_reg <= zero_reg;
            sat_out_reg  <= satseen_reg || rsat_reg || flux_clamp;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            csum_reg    <= '0;
            wsum_reg    <= '0;
            fsum_reg    <= '0;
            satseen_reg <= 1'b0;
        end else if (cmd.out_load) begin
            csum_reg    <= '0;
            wsum_reg    <= '0;
            fsum_reg    <= '0;
            satseen_reg <= 1'b0;
        end else begin
            if (cmd.acc_w) begin
                csum_reg <= csum_add[48] ? {48{1'b1}} : csum_add[47:0];
                wsum_reg <= acc_res;
                if (csum_add[48] || acc_ovf) satseen_reg <= 1'b1;
            end
            if (cmd.acc_d) begin
                fsum_reg <= acc_res;
                if (acc_ovf) satseen_reg <= 1'b1;
            end
        end
    end

endmodule

// File: rtl/core/network_node_pressure_relax_unit.sv
// network node pressure relaxation, one jacobi step of a resistor network node
// s_ channel: one word per neighbor link; s_tlast marks the node's final neighbor
// m_ channel: one word per node, after the word carrying s_tlast
// each neighbor word passes through capture, a 32x33 multiply for c1*c2,
// a 33-step restoring divide for the link conductance, then two multiply,
// round and saturating-accumulate passes on the shared multiplier;
// the divide is skipped when both conductances are zero
// a last word adds the final divide, 32 steps on the shared radix-2 divider,
// skipped when the total conductance is zero or the quotient overflows,
// before the result sits in the output register
// s_tready is high only while the sequencer waits for a word
// the output register holds a result until m_tready takes it; the next node's
// words are accepted meanwhile, and only a second result waits on the first
// reset clears the sums, the sequencer and m_tvalid; no clearing pass
module network_node_pressure_relax_unit
    import nnpr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // own_conductance, own_pressure, neighbor_conductance, neighbor_pressure
    input  logic [127:0] s_tdata,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // new_pressure, node_flux
    output logic [79:0]  m_tdata,
    // zero_conductance, saturated
    output logic [1:0]   m_tuser
);

    nnpr_cmd_t  cmd;
    nnpr_stat_t stat;

    nnpr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    nnpr_datapath #(.FRAC_BITS(FRAC_BITS)) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .cmd     (cmd),
        .stat    (stat),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

endmodule

// File: rtl/core/nnpr_checker.sv
module nnpr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata,
    input logic [1:0]  m_tuser
);

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready right after an accepted word");

    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tlast |=> !$rose(m_tvalid))
        else $error("result after a non-last word");

    a_zero_flux: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[79:32] == 48'd0 && !m_tuser[1])
        else $error("zero conductance with flux or saturation");

endmodule

bind network_node_pressure_relax_unit nnpr_checker u_nnpr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: sim/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 16;
    localparam logic [63:0] CSUM_MAX = 64'hFFFF_FFFF_FFFF;
    localparam longint FLUX_HI = 64'sh7FFF_FFFF_FFFF;
    localparam longint FLUX_LO = -64'sh7FFF_FFFF_FFFF - 1;
    localparam longint I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint I64_MIN = 64'sh8000_0000_0000_0000;

    typedef struct {
        logic [31:0] new_pressure;
        logic [47:0] node_flux;
        logic        zero_conductance;
        logic        saturated;
    } node_result_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [79:0]  m_tdata;
    logic [1:0]   m_tuser;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int errors = 0;
    bit draining = 1'b0;

    node_result_t pending_results[$];

    logic [63:0] g_total;
    longint      weighted_total;
    longint      flux_total;
    bit          sat_sticky;

    network_node_pressure_relax_unit dut (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    initial begin
        #50ms;
        $display("FAIL");
        $finish;
    end

    function automatic longint scaled_product(logic [63:0] g, logic [63:0] m, bit neg);
        logic [127:0] p;
        logic [127:0] f;
        p = g * m;
        if (neg) begin
            f = (p + ((128'd1 << FRAC) - 1)) >> FRAC;
            return -longint'(f[63:0]);
        end
        f = p >> FRAC;
        return longint'(f[63:0]);
    endfunction

    function automatic longint clamp_add(longint a, longint b);
        longint s;
        s = a + b;
        if (b > 0 && a > I64_MAX - b) begin
            sat_sticky = 1'b1;
            return I64_MAX;
        end
        if (b < 0 && a < I64_MIN - b) begin
            sat_sticky = 1'b1;
            return I64_MIN;
        end
        return s;
    endfunction

    function automatic logic [63:0] mag64(longint v);
        return v < 0 ? 64'd0 - 64'(v) : 64'(v);
    endfunction

    task automatic relax_neighbor(logic [31:0] c1, logic [31:0] xo, logic [31:0] c2,
                                  logic [31:0] xn, bit last);
        logic [63:0] s, p, q, r, g, w, t, lim;
        longint      xo_s, xn_s, diff, np, fx;
        node_result_t res;
        bit          neg, sat;
        xo_s = longint'($signed(xo));
        xn_s = longint'($signed(xn));
        diff = xo_s - xn_s;
        s = 64'(c1) + 64'(c2);
        g = 0;
        if (s != 0) begin
            p = 64'(c1) * 64'(c2);
            q = p / s;
            r = p % s;
            g = 2 * q + ((2 * r >= s) ? 1 : 0);
        end
        g_total = g_total + g;
        if (g_total > CSUM_MAX) begin
            g_total = CSUM_MAX;
            sat_sticky = 1'b1;
        end
        weighted_total = clamp_add(weighted_total,
                                   scaled_product(g, mag64(xn_s), xn_s < 0));
        flux_total = clamp_add(flux_total, scaled_product(g, mag64(diff), diff < 0));
        if (!last) return;
        sat = sat_sticky;
        res.zero_conductance = 1'b0;
        if (g_total == 0) begin
            res.zero_conductance = 1'b1;
            np = xo_s;
        end else begin
            t = g_total;
            w = mag64(weighted_total);
            neg = weighted_total < 0;
            q = w / t;
            r = w % t;
            lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
            if (q > lim) begin
                q = lim;
                sat = 1'b1;
            end else begin
                for (int i = 0; i < FRAC; i++) begin
                    r = r << 1;
                    q = q << 1;
                    if (r >= t) begin
                        r = r - t;
                        q[0] = 1'b1;
                    end
                end
                if (q > lim) begin
                    q = lim;
                    sat = 1'b1;
                end
            end
            np = neg ? -longint'(q) : longint'(q);
        end
        fx = flux_total;
        if (fx > FLUX_HI) begin
            fx = FLUX_HI;
            sat = 1'b1;
        end else if (fx < FLUX_LO) begin
            fx = FLUX_LO;
            sat = 1'b1;
        end
        res.new_pressure = np[31:0];
        res.node_flux = fx[47:0];
        res.saturated = sat;
        pending_results.insert(pending_results.size(), res);
        g_total = 0;
        weighted_total = 0;
        flux_total = 0;
        sat_sticky = 1'b0;
    endtask

    task automatic send_word(logic [31:0] c1, logic [31:0] xo, logic [31:0] c2,
                             logic [31:0] xn, bit last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {xn, c2, xo, c1};
        s_tlast <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        relax_neighbor(c1, xo, c2, xn, last);
    endtask

    always @(posedge aclk) begin
        node_result_t exp_res;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result word %h", m_tdata);
                    errors++;
                end else begin
                    exp_res = pending_results.pop_front();
                    if (m_tdata[31:0] !== exp_res.new_pressure) begin
                        $error("new_pressure exp %h got %h", exp_res.new_pressure,
                               m_tdata[31:0]);
                        errors++;
                    end
                    if (m_tdata[79:32] !== exp_res.node_flux) begin
                        $error("node_flux exp %h got %h", exp_res.node_flux,
                               m_tdata[79:32]);
                        errors++;
                    end
                    if (m_tuser[0] !== exp_res.zero_conductance) begin
                        $error("zero_conductance exp %b got %b",
                               exp_res.zero_conductance, m_tuser[0]);
                        errors++;
                    end
                    if (m_tuser[1] !== exp_res.saturated) begin
                        $error("saturated exp %b got %b", exp_res.saturated,
                               m_tuser[1]);
                        errors++;
                    end
                end
            end
            m_tready <= draining || ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic logic [31:0] rand_cond();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(32'h0004_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_press();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(32'h0002_0000) - 32'h0001_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        send_word(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000, 1);
        send_word(0, 32'h1234_5678, 0, 32'h7FFF_FFFF, 1);
        send_word(0, 32'h8000_0000, 0, 32'h8000_0000, 0);
        send_word(0, 32'h8000_0000, 32'h0001_0000, 32'h0003_0000, 1);
        send_word('1, 32'h7FFF_FFFF, '1, 32'h8000_0000, 0);
        send_word('1, 32'h7FFF_FFFF, '1, 32'h8000_0000, 0);
        send_word('1, 32'h7FFF_FFFF, '1, 32'h8000_0000, 1);
        for (int i = 0; i < 6; i++)
            send_word('1, 32'h8000_0000, '1, 32'h7FFF_FFFF, i == 5);
        send_word(32'h0000_0001, 32'h7FFF_FFFF, '1, 32'h7FFF_FFFF, 1);
        send_word(32'h0000_0001, 0, 32'h0000_0001, 32'hFFFF_FFFF, 1);
        send_word('1, 32'h5555_5555, 32'h0000_0001, 32'hAAAA_AAAA, 0);
        send_word(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'h0, 1);
    endtask

    task automatic test_random_nodes(int words);
        logic [31:0] c1, xo;
        int n, left;
        left = words;
        while (left > 0) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(40, 12) : $urandom_range(6, 1);
            c1 = rand_cond();
            xo = rand_press();
            for (int k = 0; k < n && left > 0; k++, left--) begin
                if ($urandom_range(15) == 0) begin
                    c1 = rand_cond();
                    xo = rand_press();
                end
                send_word(c1, xo, rand_cond(), rand_press(), k == n - 1 || left == 1);
            end
        end
    endtask

    task automatic test_wait_for_drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    initial begin
        g_total = 0;
        weighted_total = 0;
        flux_total = 0;
        sat_sticky = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_wait_for_drain();
        send_idle_pct = 24;
        recv_idle_pct = 71;
        test_random_nodes(280);
        test_wait_for_drain();
        send_idle_pct = 71;
        recv_idle_pct = 24;
        test_random_nodes(280);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_nodes(290);
        draining = 1'b1;
        test_wait_for_drain();
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

// File: network_node_pressure_relax_unit.f
rtl/core/nnpr_pkg.sv
rtl/core/nnpr_ctrl.sv
rtl/core/nnpr_datapath.sv
rtl/core/network_node_pressure_relax_unit.sv
rtl/core/nnpr_checker.sv
sim/testbench.sv
